@@ hw/rtl/htbd_pkg.sv @@
// Shared types and constants for the Huffman tree-walk decoder.
// No dependencies.
package htbd_pkg;

  localparam int unsigned IDX_W  = 9;
  localparam int unsigned SYM_W  = 8;
  localparam int unsigned CNT_W  = 48;
  localparam int unsigned CFG_DW = 64;
  localparam int unsigned CFG_AW = 4;

  // Index of the first code bit taken from a byte
  localparam logic [2:0] BYTE_MSB = 3'd7;

  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_DECODE  = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  localparam logic REG_ROOT     = 1'b0;
  localparam logic REG_EXPECTED = 1'b1;

  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             symbol_valid;
    logic             last;
    logic             done_res;
    logic             tree_error;
  } result_t;

endpackage

@@ hw/rtl/huffman_tree_bit_decoder_top.sv @@
// Huffman tree-walk decoder: node table memory, walk sequencer and APB registers.
// Depends on htbd_pkg.
//
// Usage: a transaction is taken when start is high and busy is low. A load
// transaction writes one node table entry; a restart returns the walk to the root
// and clears the symbol count. A decode transaction walks the eight bits of
// code_byte MSB first through the node table, a single-port synchronous memory
// with registered read data. Each code bit reads the child entry, then evaluates
// it; each decoded symbol that leaves bits in the byte re-reads the root, and each
// byte adds a start step and a flush step. busy stays high while the byte is
// walked, and a tree error or the expected symbol total ends the byte early. A
// decode while the decoder is already finished leaves busy low and answers in the
// next cycle. Results appear on out_* for exactly one cycle with out_valid high and
// cannot be held off; one result is kept in a pending register until the next one
// or the end of the byte is known, so that last marks the final result of the byte.
// busy falls in the cycle in which that final result is driven, so the next
// transaction can be taken at the edge that ends it.
// The node table has no reset; entries read before they are loaded are undefined.
// Configuration (root_node at 0x0, expected_symbols at 0x8) is written by the user
// only while busy is low; the block itself does not enforce this. A root_node
// write also moves the walk to the new root.
module huffman_tree_bit_decoder_top #(
  parameter int unsigned NODE_ENTRIES = 512
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_action,
  input  logic [htbd_pkg::IDX_W-1:0]   in_node_index,
  input  logic                         in_node_is_leaf,
  input  logic [htbd_pkg::SYM_W-1:0]   in_node_symbol,
  input  logic [htbd_pkg::IDX_W-1:0]   in_left_child,
  input  logic [htbd_pkg::IDX_W-1:0]   in_right_child,
  input  logic [htbd_pkg::SYM_W-1:0]   in_code_byte,
  output logic                         out_valid,
  output logic [htbd_pkg::SYM_W-1:0]   out_symbol,
  output logic                         out_symbol_valid,
  output logic                         out_last,
  output logic                         out_done_res,
  output logic                         out_tree_error,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [htbd_pkg::CFG_AW-1:0]  paddr,
  input  logic [htbd_pkg::CFG_DW-1:0]  pwdata,
  output logic [htbd_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready
);
  import htbd_pkg::*;

  localparam int unsigned AW = (NODE_ENTRIES > 1) ? $clog2(NODE_ENTRIES) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;  // read the entry at the walk position
  localparam logic [2:0] S_EVAL  = 3'd2;  // pick a child of the current entry
  localparam logic [2:0] S_NEXT  = 3'd3;  // inspect the child entry
  localparam logic [2:0] S_FLUSH = 3'd4;  // drive the final result of the byte

  // Node table
  logic [$bits(node_t)-1:0] mem [NODE_ENTRIES];
  node_t                    rd_data_r;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  node_t                    mem_wdata;
  logic                     mem_re;
  logic [AW-1:0]            mem_raddr;

  // Control and architectural state
  logic [2:0]       state_r,      state_nxt;
  logic [IDX_W-1:0] root_r,       root_nxt;
  logic [CNT_W-1:0] expected_r,   expected_nxt;
  logic [IDX_W-1:0] pos_r,        pos_nxt;
  logic [CNT_W-1:0] count_r,      count_nxt;
  logic             fin_r,        fin_nxt;
  logic [SYM_W-1:0] byte_r,       byte_nxt;
  logic [2:0]       bit_r,        bit_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  result_t          pend_r,       pend_nxt;
  logic             out_valid_r,  out_valid_nxt;
  result_t          out_res_r,    out_res_nxt;

  logic             accept;
  logic             cfg_wr;
  logic             push_en;
  result_t          push_res;
  logic             emit_en;
  result_t          emit_res;
  logic             code_bit;
  logic [IDX_W-1:0] child;
  logic [CNT_W-1:0] count_inc;
  logic             hit_expected;

  function automatic logic in_range(input logic [IDX_W-1:0] idx);
    return 32'(idx) < NODE_ENTRIES;
  endfunction

  function automatic result_t err_result();
    result_t r;
    r              = '0;
    r.tree_error   = 1'b1;
    r.last         = 1'b1;
    return r;
  endfunction

  assign accept       = start && !busy;
  assign cfg_wr       = psel && penable && pwrite && pready;
  assign code_bit     = byte_r[bit_r];
  assign child        = code_bit ? rd_data_r.right : rd_data_r.left;
  assign count_inc    = count_r + CNT_W'(1);
  assign hit_expected = (count_inc == expected_r);

  always_comb begin
    state_nxt      = state_r;
    root_nxt       = root_r;
    expected_nxt   = expected_r;
    pos_nxt        = pos_r;
    count_nxt      = count_r;
    fin_nxt        = fin_r;
    byte_nxt       = byte_r;
    bit_nxt        = bit_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    mem_we         = 1'b0;
    mem_waddr      = AW'(in_node_index);
    mem_wdata      = '{leaf: in_node_is_leaf, symbol: in_node_symbol,
                       left: in_left_child, right: in_right_child};
    mem_re         = 1'b0;
    mem_raddr      = AW'(pos_r);
    push_en        = 1'b0;
    push_res       = '0;
    emit_en        = 1'b0;
    emit_res       = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_LOAD: begin
              mem_we = in_range(in_node_index);
            end
            ACT_RESTART: begin
              pos_nxt   = root_r;
              count_nxt = '0;
              fin_nxt   = 1'b0;
            end
            ACT_DECODE: begin
              if (fin_r || (count_r >= expected_r)) begin
                // Already finished: answer at once, ignore the byte
                fin_nxt           = 1'b1;
                emit_en           = 1'b1;
                emit_res.last     = 1'b1;
                emit_res.done_res = 1'b1;
              end else begin
                byte_nxt  = in_code_byte;
                bit_nxt   = BYTE_MSB;
                state_nxt = S_START;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_START: begin
        if (!in_range(pos_r)) begin
          push_en   = 1'b1;
          push_res  = err_result();
          pos_nxt   = root_r;
          state_nxt = S_FLUSH;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(pos_r);
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (rd_data_r.leaf || !in_range(child)) begin
          push_en   = 1'b1;
          push_res  = err_result();
          pos_nxt   = root_r;
          state_nxt = S_FLUSH;
        end else begin
          // Advance now; a leaf child sends the walk back to the root
          mem_re    = 1'b1;
          mem_raddr = AW'(child);
          pos_nxt   = child;
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        bit_nxt = bit_r - 3'd1;
        if (rd_data_r.leaf) begin
          push_en               = 1'b1;
          push_res.symbol       = rd_data_r.symbol;
          push_res.symbol_valid = 1'b1;
          push_res.done_res     = hit_expected;
          pos_nxt               = root_r;
          count_nxt             = count_inc;
          fin_nxt               = hit_expected;
          state_nxt             = (hit_expected || bit_r == '0) ? S_FLUSH : S_START;
        end else begin
          state_nxt = (bit_r == '0) ? S_FLUSH : S_EVAL;
        end
      end
      S_FLUSH: begin
        emit_en = 1'b1;
        if (pend_valid_r) begin
          emit_res      = pend_r;
          emit_res.last = 1'b1;
        end else begin
          emit_res.last     = 1'b1;
          emit_res.done_res = fin_r;
        end
        pend_valid_nxt = 1'b0;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A new result pushes the held one out; it cannot be the last of the byte
    if (push_en) begin
      if (pend_valid_r) begin
        emit_en  = 1'b1;
        emit_res = pend_r;
      end
      pend_valid_nxt = 1'b1;
      pend_nxt       = push_res;
    end

    if (cfg_wr) begin
      case (paddr[3])
        REG_ROOT: begin
          root_nxt = pwdata[IDX_W-1:0];
          pos_nxt  = pwdata[IDX_W-1:0];
        end
        REG_EXPECTED: begin
          expected_nxt = pwdata[CNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_nxt = emit_en;
  assign out_res_nxt   = emit_res;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= node_t'(mem[mem_raddr]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      root_r       <= '0;
      expected_r   <= '0;
      pos_r        <= '0;
      count_r      <= '0;
      fin_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      root_r       <= root_nxt;
      expected_r   <= expected_nxt;
      pos_r        <= pos_nxt;
      count_r      <= count_nxt;
      fin_r        <= fin_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk) begin
    byte_r    <= byte_nxt;
    bit_r     <= bit_nxt;
    pend_r    <= pend_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_symbol       = out_res_r.symbol;
  assign out_symbol_valid = out_res_r.symbol_valid;
  assign out_last         = out_res_r.last;
  assign out_done_res     = out_res_r.done_res;
  assign out_tree_error   = out_res_r.tree_error;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_EXPECTED) ? CFG_DW'(expected_r) : CFG_DW'(root_r);

  // A decode transaction either answers at once or keeps the block busy
  a_decode_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action == ACT_DECODE) |=> (busy || out_valid))
    else $error("decode transaction produced neither result nor busy");

  // A result that is not last means more of the same byte is still on its way
  a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("non-final result while idle");

  // An error ends the byte and never carries a symbol or done
  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_tree_error) |-> (out_last && !out_symbol_valid && !out_done_res))
    else $error("malformed error result");

  // A result with no symbol is always the final one of the byte
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_symbol_valid) |-> (out_last && out_symbol == '0))
    else $error("empty result not marked last");

endmodule

@@ tb/sv/huffman_tree_bit_decoder_top_tb.sv @@
// Self-checking testbench for the Huffman tree-walk decoder: directed node tables,
// then random trees, code bytes and register settings checked against a local predictor.
// Depends on htbd_pkg and huffman_tree_bit_decoder_top.
module huffman_tree_bit_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import htbd_pkg::*;

  localparam int unsigned TABLE_DEPTH = 512;
  // Number of counted transactions in the random part
  localparam int RANDOM_ITEMS = 190;
  // Longer than the longest time a decode keeps the block busy; waited
  // before touching registers or ending the run
  localparam int SETTLE_CYCLES = 40;
  // The block has no name for action 3; it must be ignored
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]       action;
    logic [IDX_W-1:0] node_index;
    logic             node_is_leaf;
    logic [SYM_W-1:0] node_symbol;
    logic [IDX_W-1:0] left_child;
    logic [IDX_W-1:0] right_child;
    logic [SYM_W-1:0] code_byte;
  } code_txn_t;

  // Tracks the decoder state, predicts the results of every accepted
  // transaction and checks the results that come out.
  class tree_walk_scoreboard;
    node_t            node_mem [TABLE_DEPTH];
    bit               loaded   [TABLE_DEPTH];
    logic [IDX_W-1:0] walk_pos;
    logic [IDX_W-1:0] root_idx;
    logic [CNT_W-1:0] symbol_count;
    logic [CNT_W-1:0] symbol_target;
    bit               finished;
    result_t          awaited[$];
    int               mismatches;
    int               checked;
    int               symbols_seen;
    int               errors_seen;

    function new();
      foreach (loaded[i]) begin
        loaded[i]   = 1'b0;
        node_mem[i] = '0;
      end
      walk_pos      = '0;
      root_idx      = '0;
      symbol_count  = '0;
      symbol_target = '0;
      finished      = 1'b0;
    endfunction

    function void apply_register(logic sel, logic [CFG_DW-1:0] value);
      if (sel == REG_ROOT) begin
        root_idx = value[IDX_W-1:0];
        walk_pos = root_idx;
      end else begin
        symbol_target = value[CNT_W-1:0];
      end
    endfunction

    function void walk_code_byte(logic [SYM_W-1:0] code);
      result_t          batch[$];
      result_t          r;
      node_t            here;
      node_t            child;
      logic [IDX_W-1:0] next_idx;
      bit               broke;
      int               b;
      broke = 1'b0;
      if (!finished && symbol_count >= symbol_target) finished = 1'b1;
      if (finished) begin
        r = '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0};
        awaited.push_back(r);
        return;
      end
      for (b = BYTE_MSB; b >= 0 && !finished && !broke; b--) begin
        here = node_mem[walk_pos];
        if (here.leaf) begin
          // leaf where an internal node belongs: drop the rest of the byte
          walk_pos = root_idx;
          r = '{8'h00, 1'b0, 1'b1, 1'b0, 1'b1};
          batch.push_back(r);
          broke = 1'b1;
        end else begin
          next_idx = code[b] ? here.right : here.left;
          child = node_mem[next_idx];
          if (child.leaf) begin
            walk_pos = root_idx;
            symbol_count++;
            if (symbol_count == symbol_target) finished = 1'b1;
            r = '{child.symbol, 1'b1, 1'b0, finished, 1'b0};
            batch.push_back(r);
          end else begin
            walk_pos = next_idx;
          end
        end
      end
      if (batch.size() == 0) begin
        r = '{8'h00, 1'b0, 1'b1, finished, 1'b0};
        batch.push_back(r);
      end else begin
        r = batch.pop_back();
        r.last = 1'b1;
        batch.push_back(r);
      end
      foreach (batch[i]) awaited.push_back(batch[i]);
    endfunction

    function void note_transaction(code_txn_t t);
      case (t.action)
        ACT_LOAD: begin
          node_mem[t.node_index] = {t.node_is_leaf, t.node_symbol, t.left_child, t.right_child};
          loaded[t.node_index] = 1'b1;
        end
        ACT_RESTART: begin
          walk_pos     = root_idx;
          symbol_count = '0;
          finished     = 1'b0;
        end
        ACT_DECODE: walk_code_byte(t.code_byte);
        default: ;
      endcase
    endfunction

    // First table entry that decoding this byte would read before it was
    // ever loaded, or -1 when the walk stays on loaded entries.
    function int first_unloaded(logic [SYM_W-1:0] code);
      logic [IDX_W-1:0] pos;
      logic [IDX_W-1:0] next_idx;
      logic [CNT_W-1:0] count;
      node_t            here;
      int               b;
      // the root is re-read after every symbol, so it must always be loaded
      if (!loaded[root_idx]) return int'(root_idx);
      if (finished || symbol_count >= symbol_target) return -1;
      pos   = walk_pos;
      count = symbol_count;
      for (b = BYTE_MSB; b >= 0; b--) begin
        if (!loaded[pos]) return int'(pos);
        here = node_mem[pos];
        if (here.leaf) return -1;
        next_idx = code[b] ? here.right : here.left;
        if (!loaded[next_idx]) return int'(next_idx);
        if (node_mem[next_idx].leaf) begin
          count++;
          if (count == symbol_target) return -1;
          pos = root_idx;
        end else begin
          pos = next_idx;
        end
      end
      return -1;
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result with nothing awaited: symbol %02h valid %b last %b",
                                  got.symbol, got.symbol_valid, got.last));
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (want.symbol_valid) symbols_seen++;
      if (want.tree_error) errors_seen++;
      if (got.symbol !== want.symbol)
        report_mismatch($sformatf("symbol got %02h want %02h", got.symbol, want.symbol));
      if (got.symbol_valid !== want.symbol_valid)
        report_mismatch($sformatf("symbol_valid got %b want %b",
                                  got.symbol_valid, want.symbol_valid));
      if (got.last !== want.last)
        report_mismatch($sformatf("last got %b want %b", got.last, want.last));
      if (got.done_res !== want.done_res)
        report_mismatch($sformatf("done_res got %b want %b", got.done_res, want.done_res));
      if (got.tree_error !== want.tree_error)
        report_mismatch($sformatf("tree_error got %b want %b",
                                  got.tree_error, want.tree_error));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [1:0]          in_action;
  logic [IDX_W-1:0]    in_node_index;
  logic                in_node_is_leaf;
  logic [SYM_W-1:0]    in_node_symbol;
  logic [IDX_W-1:0]    in_left_child;
  logic [IDX_W-1:0]    in_right_child;
  logic [SYM_W-1:0]    in_code_byte;
  logic                out_valid;
  logic [SYM_W-1:0]    out_symbol;
  logic                out_symbol_valid;
  logic                out_last;
  logic                out_done_res;
  logic                out_tree_error;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  tree_walk_scoreboard sb = new();

  bit back_to_back;   // when set, transactions are sent with no gap between them
  int sent_count;     // transactions that the block acts on
  int cfg_writes;

  huffman_tree_bit_decoder_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_node_index    (in_node_index),
    .in_node_is_leaf  (in_node_is_leaf),
    .in_node_symbol   (in_node_symbol),
    .in_left_child    (in_left_child),
    .in_right_child   (in_right_child),
    .in_code_byte     (in_code_byte),
    .out_valid        (out_valid),
    .out_symbol       (out_symbol),
    .out_symbol_valid (out_symbol_valid),
    .out_last         (out_last),
    .out_done_res     (out_done_res),
    .out_tree_error   (out_tree_error),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Results last one cycle and cannot be held off: take each one at the
  // edge that closes its cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      sb.check_result('{out_symbol, out_symbol_valid, out_last, out_done_res, out_tree_error});
  end

  // Mostly no gap, often a short one, rarely a long one.
  function automatic int pick_gap();
    int r;
    if (back_to_back) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 9);
    return $urandom_range(10, 40);
  endfunction

  // Fill every field with noise, then set the action.
  function automatic code_txn_t random_txn(logic [1:0] act);
    code_txn_t t;
    t.action       = act;
    t.node_index   = IDX_W'($urandom);
    t.node_is_leaf = 1'($urandom);
    t.node_symbol  = SYM_W'($urandom);
    t.left_child   = IDX_W'($urandom);
    t.right_child  = IDX_W'($urandom);
    t.code_byte    = SYM_W'($urandom);
    return t;
  endfunction

  // Present one transaction and hold it until the block takes it. start
  // stays high afterwards so a following transaction can go back to back.
  task automatic drive_txn(code_txn_t t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_action       <= t.action;
    in_node_index   <= t.node_index;
    in_node_is_leaf <= t.node_is_leaf;
    in_node_symbol  <= t.node_symbol;
    in_left_child   <= t.left_child;
    in_right_child  <= t.right_child;
    in_code_byte    <= t.code_byte;
    start           <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_transaction(t);
    if (t.action != ACT_UNUSED) sent_count++;
  endtask

  task automatic send_load(logic [IDX_W-1:0] idx, logic leaf, logic [SYM_W-1:0] sym,
                           logic [IDX_W-1:0] lhs, logic [IDX_W-1:0] rhs);
    code_txn_t t;
    t = random_txn(ACT_LOAD);
    t.node_index   = idx;
    t.node_is_leaf = leaf;
    t.node_symbol  = sym;
    t.left_child   = lhs;
    t.right_child  = rhs;
    drive_txn(t);
  endtask

  task automatic send_action(logic [1:0] act);
    drive_txn(random_txn(act));
  endtask

  // Before decoding, load a leaf into any entry the walk would read
  // that was never loaded; such reads are undefined in the block.
  task automatic send_decode(logic [SYM_W-1:0] code);
    code_txn_t t;
    int        hole;
    hole = sb.first_unloaded(code);
    while (hole >= 0) begin
      send_load(IDX_W'(hole), 1'b1, SYM_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
      hole = sb.first_unloaded(code);
    end
    t = random_txn(ACT_DECODE);
    t.code_byte = code;
    drive_txn(t);
  endtask

  // Registers change only while the block is idle: drain all awaited
  // results, give loads and restarts time to finish, then do one write.
  task automatic write_register(logic sel, logic [CFG_DW-1:0] value);
    start <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {sel, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.apply_register(sel, value);
    cfg_writes++;
  endtask

  // Build a random full binary tree at scattered table entries: load the
  // leaves, then join random pairs of subtrees until one root remains.
  task automatic build_random_tree(output logic [IDX_W-1:0] root_out,
                                   output logic [IDX_W-1:0] leaf_out);
    logic [IDX_W-1:0] subtrees[$];
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] lhs;
    logic [IDX_W-1:0] rhs;
    bit               used [TABLE_DEPTH];
    int               n;
    int               p;
    n = $urandom_range(2, 8);
    repeat (n) begin
      do idx = IDX_W'($urandom); while (used[idx]);
      used[idx] = 1'b1;
      send_load(idx, 1'b1, SYM_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
      subtrees.push_back(idx);
    end
    leaf_out = subtrees[0];
    while (subtrees.size() > 1) begin
      p = $urandom_range(0, subtrees.size() - 1);
      lhs = subtrees[p];
      subtrees.delete(p);
      p = $urandom_range(0, subtrees.size() - 1);
      rhs = subtrees[p];
      subtrees.delete(p);
      do idx = IDX_W'($urandom); while (used[idx]);
      used[idx] = 1'b1;
      send_load(idx, 1'b0, SYM_W'($urandom), lhs, rhs);
      subtrees.push_back(idx);
    end
    root_out = subtrees[0];
  endtask

  initial begin
    logic [IDX_W-1:0] root;
    logic [IDX_W-1:0] leaf;
    logic [CFG_DW-1:0] target;
    int               random_goal;
    int               r;

    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_action       <= ACT_LOAD;
    in_node_index   <= '0;
    in_node_is_leaf <= 1'b0;
    in_node_symbol  <= '0;
    in_left_child   <= '0;
    in_right_child  <= '0;
    in_code_byte    <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    back_to_back    = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a small tree rooted at entry 0 that uses both ends of the
    // index and symbol ranges. 0 -> left leaf 1 (00), right internal 2;
    // 2 -> left leaf 3 (ff), right leaf 511 (a5).
    send_load(9'd0, 1'b0, 8'h00, 9'd1, 9'd2);
    send_load(9'd1, 1'b1, 8'h00, 9'd0, 9'd0);
    send_load(9'd2, 1'b0, 8'h00, 9'd3, 9'd511);
    send_load(9'd3, 1'b1, 8'hff, 9'd0, 9'd0);
    send_load(9'd511, 1'b1, 8'ha5, 9'd511, 9'd511);
    // expected_symbols is still zero after reset: count already reached
    send_decode(8'h00);
    // action 3 carries nothing and must leave no trace
    drive_txn('{ACT_UNUSED, 9'h1ff, 1'b1, 8'hff, 9'h1ff, 9'h1ff, 8'hff});
    // decoder is now finished
    send_decode(8'hff);

    // Never stop: maximum symbol total
    write_register(REG_EXPECTED, 64'h0000_ffff_ffff_ffff);
    send_action(ACT_RESTART);
    send_decode(8'h00);   // eight symbols from one byte
    send_decode(8'hff);   // four symbols from the far right leaf
    send_decode(8'hb3);
    send_decode(8'h01);   // code left open across the byte boundary
    send_decode(8'h7f);

    // Root on a leaf: tree error
    write_register(REG_ROOT, 64'd511);
    send_decode(8'h55);

    // Node 4 loops to itself on a 0 bit, so an all-zero byte yields nothing
    send_load(9'd4, 1'b0, 8'h00, 9'd4, 9'd1);
    write_register(REG_ROOT, 64'd4);
    send_decode(8'h00);
    send_decode(8'h01);

    // Stop after three symbols, part way through a byte
    write_register(REG_ROOT, 64'd0);
    write_register(REG_EXPECTED, 64'd3);
    send_action(ACT_RESTART);
    send_decode(8'h00);
    send_decode(8'h00);

    // Lower the total below the count already decoded
    write_register(REG_EXPECTED, 64'd10);
    send_action(ACT_RESTART);
    send_decode(8'h00);
    write_register(REG_EXPECTED, 64'd2);
    send_decode(8'hff);
    send_action(ACT_RESTART);

    // Random: each round loads a fresh tree, picks root and total, then
    // decodes random bytes with some noise loads, restarts and action 3.
    random_goal = sent_count + RANDOM_ITEMS;
    while (sent_count < random_goal) begin
      back_to_back = ($urandom_range(0, 3) == 0);
      build_random_tree(root, leaf);
      if ($urandom_range(0, 7) == 0) root = leaf;
      write_register(REG_ROOT, CFG_DW'(root));
      case ($urandom_range(0, 7))
        0: target = 64'h0000_ffff_ffff_ffff;
        1: target = {$urandom, $urandom};
        2: target = '0;
        default: target = CFG_DW'($urandom_range(1, 30));
      endcase
      write_register(REG_EXPECTED, target);
      if ($urandom_range(0, 3) != 0) send_action(ACT_RESTART);
      repeat ($urandom_range(6, 14)) begin
        r = $urandom_range(0, 19);
        if (r == 0) drive_txn(random_txn(ACT_LOAD));
        else if (r == 1) send_action(ACT_UNUSED);
        else if (r == 2) send_action(ACT_RESTART);
        else send_decode(SYM_W'($urandom));
      end
    end

    // Drain, then allow the longest decode to finish before judging
    start <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d transactions and %0d register writes.", sent_count, cfg_writes);
    $display("Checked %0d results: %0d symbols, %0d tree errors, %0d mismatches.",
             sb.checked, sb.symbols_seen, sb.errors_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS huffman_tree_bit_decoder_top");
    end else begin
      $display("FAIL huffman_tree_bit_decoder_top");
    end
    $finish;
  end

  // Watchdog: ends a run that hangs
  initial begin
    #2000000;
    $display("Timed out with %0d results still awaited.", sb.awaited.size());
    $display("FAIL huffman_tree_bit_decoder_top");
    $finish;
  end

endmodule
